// ===== src/rc4_pkg.sv =====
// shared constants, types and the sequencer control store for the rc4 core
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int SBOX_DEPTH = 256;
   localparam int SBOX_AW    = $clog2(SBOX_DEPTH);
   localparam int KEY_MAX    = 256;
   localparam int KEY_AW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int KEY_CW     = $clog2(KEY_MAX + 1);
   localparam logic [SBOX_AW-1:0] K_LAST = SBOX_AW'(SBOX_DEPTH - 1);

   localparam int STEP_W = 4;

   // operation codes on the request channel
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef enum logic [STEP_W-1:0] {
      ST_FETCH      = 4'd0,
      ST_GEN_J      = 4'd1,
      ST_GEN_SWAP_I = 4'd2,
      ST_GEN_SWAP_J = 4'd3,
      ST_GEN_OUT    = 4'd4,
      ST_FILL       = 4'd5,
      ST_FILL_END   = 4'd6,
      ST_KS_READ    = 4'd7,
      ST_KS_J       = 4'd8,
      ST_KS_SWAP_K  = 4'd9,
      ST_KS_SWAP_J  = 4'd10,
      ST_DONE       = 4'd11
   } step_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_I_NEXT,
      RD_K,
      RD_J_GEN,
      RD_J_KS,
      RD_SUM
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_K_IDENT,
      WR_I_RDATA,
      WR_J_SI,
      WR_K_RDATA
   } wr_sel_type;

   typedef enum logic [1:0] {
      J_HOLD,
      J_GEN,
      J_KS
   } j_op_type;

   typedef enum logic [2:0] {
      JMP_GOTO,
      JMP_LOOP_K,
      JMP_NO_SCHED,
      JMP_DISPATCH,
      JMP_OUT,
      JMP_NEXT
   } jmp_type;

   typedef struct packed {
      logic       ready;
      rd_sel_type s_rd;
      wr_sel_type s_wr;
      j_op_type   j_op;
      logic       ld_si;
      logic       ld_sj;
      logic       k_inc;
      logic       kidx_step;
      logic       key_rd;
      logic       clr_idx;
      logic       out_ld;
      jmp_type    jmp;
      step_type   target;
   } ctrl_type;

   localparam ctrl_type CTRL_IDLE = '{
      ready:     1'b0,
      s_rd:      RD_NONE,
      s_wr:      WR_NONE,
      j_op:      J_HOLD,
      ld_si:     1'b0,
      ld_sj:     1'b0,
      k_inc:     1'b0,
      kidx_step: 1'b0,
      key_rd:    1'b0,
      clr_idx:   1'b0,
      out_ld:    1'b0,
      jmp:       JMP_GOTO,
      target:    ST_FETCH
   };

   // control store: one word per step
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type c;
      c = CTRL_IDLE;
      case (step)
         ST_FETCH: begin
            c.ready = 1'b1;
            c.s_rd  = RD_I_NEXT;
            c.jmp   = JMP_DISPATCH;
         end
         ST_GEN_J: begin
            c.s_rd  = RD_J_GEN;
            c.j_op  = J_GEN;
            c.ld_si = 1'b1;
            c.jmp   = JMP_NEXT;
         end
         ST_GEN_SWAP_I: begin
            c.s_wr  = WR_I_RDATA;
            c.ld_sj = 1'b1;
            c.jmp   = JMP_NEXT;
         end
         ST_GEN_SWAP_J: begin
            c.s_wr = WR_J_SI;
            c.s_rd = RD_SUM;
            c.jmp  = JMP_NEXT;
         end
         ST_GEN_OUT: begin
            c.out_ld = 1'b1;
            c.jmp    = JMP_OUT;
            c.target = ST_FETCH;
         end
         ST_FILL: begin
            c.s_wr   = WR_K_IDENT;
            c.k_inc  = 1'b1;
            c.jmp    = JMP_LOOP_K;
            c.target = ST_FILL;
         end
         ST_FILL_END: begin
            c.jmp    = JMP_NO_SCHED;
            c.target = ST_DONE;
         end
         ST_KS_READ: begin
            c.s_rd   = RD_K;
            c.key_rd = 1'b1;
            c.jmp    = JMP_NEXT;
         end
         ST_KS_J: begin
            c.s_rd  = RD_J_KS;
            c.j_op  = J_KS;
            c.ld_si = 1'b1;
            c.jmp   = JMP_NEXT;
         end
         ST_KS_SWAP_K: begin
            c.s_wr = WR_K_RDATA;
            c.jmp  = JMP_NEXT;
         end
         ST_KS_SWAP_J: begin
            c.s_wr      = WR_J_SI;
            c.k_inc     = 1'b1;
            c.kidx_step = 1'b1;
            c.jmp       = JMP_LOOP_K;
            c.target    = ST_KS_READ;
         end
         ST_DONE: begin
            c.clr_idx = 1'b1;
            c.jmp     = JMP_GOTO;
            c.target  = ST_FETCH;
         end
         default: begin
            c.jmp    = JMP_GOTO;
            c.target = ST_FETCH;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== src/rc4_req_if.sv =====
// request channel: key and data bytes into the rc4 core
interface rc4_req_if;
   import rc4_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [BYTE_W-1:0] value;
   logic              last;

   modport source (output valid, output operation, output value, output last, input ready);
   modport sink   (input valid, input operation, input value, input last, output ready);
endinterface

// ===== src/rc4_rsp_if.sv =====
// response channel: cipher bytes out of the rc4 core
interface rc4_rsp_if;
   import rc4_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] result_byte;
   logic [BYTE_W-1:0] keystream_byte;
   logic              last_out;

   modport source (output valid, output result_byte, output keystream_byte, output last_out,
                   input ready);
   modport sink   (input valid, input result_byte, input keystream_byte, input last_out,
                   output ready);
endinterface

// ===== src/rc4_ram.sv =====
// generic single write port ram with registered read
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/rc4_stream_cipher_core.sv =====
// rc4 stream cipher core: microcoded sequencer over one s-box ram and a key store
//
//  channel  dir  beat carries                              notes
//  req_chan in   operation, value, last                    key byte (0) or data byte (1)
//  rsp_chan out  result_byte, keystream_byte, last_out     one beat per data byte
//
// a data byte is accepted in the fetch step and worked through gen_j, gen_swap_i, gen_swap_j
// and gen_out, which loads the result register before the next byte is taken. the s-box ram
// has one read port, so S[i], S[j] and S[S[i]+S[j]] are read in turn, with the swap written
// back between them. a key byte that is not last is stored at fetch. the last key byte
// starts the identity fill and the schedule, whose rounds read S[k], the key byte and S[j]
// and write the swap back; req_chan.ready is low until both end. after reset the sequencer
// runs the identity fill as a clearing pass with req_chan.ready low. a stalled rsp_chan
// holds the result register; the next beat is still accepted and worked up to its last step.
module rc4_stream_cipher_core (
   input  logic      clock,
   input  logic      reset,
   rc4_req_if.sink   req_chan,
   rc4_rsp_if.source rsp_chan
);
   import rc4_pkg::*;

   // sequencer
   step_type pc_ff, pc_in;
   ctrl_type ctrl;

   // datapath registers
   logic [SBOX_AW-1:0] i_ff, i_in;
   logic [SBOX_AW-1:0] j_ff, j_in;
   logic [SBOX_AW-1:0] k_ff, k_in;
   logic [KEY_AW-1:0]  kidx_ff, kidx_in;
   logic [KEY_CW-1:0]  key_count_ff, key_count_in;
   logic               sched_ff, sched_in;
   logic [BYTE_W-1:0]  si_ff, si_in;
   logic [BYTE_W-1:0]  sj_ff, sj_in;
   logic               fwd_ff, fwd_in;
   logic [BYTE_W-1:0]  value_ff, value_in;
   logic               last_ff, last_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  result_ff, result_in;
   logic [BYTE_W-1:0]  ks_ff, ks_in;
   logic               last_out_ff, last_out_in;

   // handshake decode
   logic accept, data_acc, key_acc, key_last, out_free;

   // s-box ram port
   logic               s_re, s_we;
   logic [SBOX_AW-1:0] s_raddr, s_waddr;
   logic [BYTE_W-1:0]  s_wdata, s_rdata;

   // key store port
   logic               key_we;
   logic [BYTE_W-1:0]  key_rdata;

   // address arithmetic; i_next, j_gen, j_ks and sum wrap mod 256
   logic [SBOX_AW-1:0] i_next, j_gen, j_ks, sum;
   logic [KEY_CW-1:0]  kidx_inc;
   logic [BYTE_W-1:0]  ks;

   assign ctrl = ucode(pc_ff);

   assign req_chan.ready = ctrl.ready;
   assign accept   = req_chan.valid && ctrl.ready;
   assign data_acc = accept && (req_chan.operation == OP_DATA);
   assign key_acc  = accept && (req_chan.operation == OP_KEY);
   assign key_last = key_acc && req_chan.last;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign i_next = i_ff + 1'b1;
   assign j_gen  = j_ff + s_rdata;
   assign j_ks   = j_ff + s_rdata + key_rdata;
   assign sum    = si_ff + sj_ff;

   // keystream byte; forwarded when S[i]+S[j] hit the entry written in the same cycle
   assign ks = fwd_ff ? si_ff : s_rdata;

   // key store writes stop once KEY_MAX bytes are held
   assign key_we   = key_acc && (key_count_ff < KEY_CW'(KEY_MAX));
   assign kidx_inc = KEY_CW'(kidx_ff) + 1'b1;

   // s-box read select
   always_comb begin
      s_re    = 1'b0;
      s_raddr = k_ff;
      case (ctrl.s_rd)
         RD_NONE: begin
            s_re = 1'b0;
         end
         RD_I_NEXT: begin
            s_re    = data_acc;
            s_raddr = i_next;
         end
         RD_K: begin
            s_re    = 1'b1;
            s_raddr = k_ff;
         end
         RD_J_GEN: begin
            s_re    = 1'b1;
            s_raddr = j_gen;
         end
         RD_J_KS: begin
            s_re    = 1'b1;
            s_raddr = j_ks;
         end
         RD_SUM: begin
            s_re    = 1'b1;
            s_raddr = sum;
         end
         default: begin
            s_re = 1'b0;
         end
      endcase
   end

   // s-box write select
   always_comb begin
      s_we    = 1'b0;
      s_waddr = k_ff;
      s_wdata = s_rdata;
      case (ctrl.s_wr)
         WR_NONE: begin
            s_we = 1'b0;
         end
         WR_K_IDENT: begin
            s_we    = 1'b1;
            s_waddr = k_ff;
            s_wdata = BYTE_W'(k_ff);
         end
         WR_I_RDATA: begin
            s_we    = 1'b1;
            s_waddr = i_ff;
            s_wdata = s_rdata;
         end
         WR_J_SI: begin
            s_we    = 1'b1;
            s_waddr = j_ff;
            s_wdata = si_ff;
         end
         WR_K_RDATA: begin
            s_we    = 1'b1;
            s_waddr = k_ff;
            s_wdata = s_rdata;
         end
         default: begin
            s_we = 1'b0;
         end
      endcase
   end

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SBOX_DEPTH)
   ) u_sbox (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_MAX)
   ) u_key_store (
      .clock (clock),
      .we    (key_we),
      .waddr (key_count_ff[KEY_AW-1:0]),
      .wdata (req_chan.value),
      .re    (ctrl.key_rd),
      .raddr (kidx_ff),
      .rdata (key_rdata)
   );

   // next step
   always_comb begin
      pc_in = pc_ff;
      case (ctrl.jmp)
         JMP_GOTO: begin
            pc_in = ctrl.target;
         end
         JMP_NEXT: begin
            pc_in = step_type'(pc_ff + 1'b1);
         end
         JMP_LOOP_K: begin
            pc_in = (k_ff != K_LAST) ? ctrl.target : step_type'(pc_ff + 1'b1);
         end
         JMP_NO_SCHED: begin
            pc_in = !sched_ff ? ctrl.target : step_type'(pc_ff + 1'b1);
         end
         JMP_DISPATCH: begin
            if (data_acc) begin
               pc_in = ST_GEN_J;
            end else if (key_last) begin
               pc_in = ST_FILL;
            end else begin
               pc_in = ST_FETCH;
            end
         end
         JMP_OUT: begin
            pc_in = out_free ? ctrl.target : pc_ff;
         end
         default: begin
            pc_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_FILL;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // datapath next values
   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kidx_in      = kidx_ff;
      key_count_in = key_count_ff;
      sched_in     = sched_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      fwd_in       = fwd_ff;
      value_in     = value_ff;
      last_in      = last_ff;

      // generator
      if (data_acc) begin
         i_in     = i_next;
         value_in = req_chan.value;
         last_in  = req_chan.last;
      end
      case (ctrl.j_op)
         J_HOLD:  j_in = j_ff;
         J_GEN:   j_in = j_gen;
         J_KS:    j_in = j_ks;
         default: j_in = j_ff;
      endcase
      if (ctrl.ld_si) begin
         si_in = s_rdata;
      end
      if (ctrl.ld_sj) begin
         sj_in = s_rdata;
      end
      if (ctrl.s_rd == RD_SUM) begin
         fwd_in = (sum == j_ff);
      end

      // key load and schedule
      if (key_we) begin
         key_count_in = key_count_ff + 1'b1;
      end
      if (ctrl.k_inc) begin
         k_in = k_ff + 1'b1;
      end
      if (ctrl.kidx_step) begin
         // key index runs 0 .. key_count-1; an empty key keeps it at zero
         kidx_in = (kidx_inc >= key_count_ff) ? '0 : kidx_inc[KEY_AW-1:0];
      end
      if (key_last) begin
         sched_in = 1'b1;
         j_in     = '0;
         k_in     = '0;
         kidx_in  = '0;
      end
      if (ctrl.clr_idx) begin
         i_in         = '0;
         j_in         = '0;
         key_count_in = '0;
         sched_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         kidx_ff      <= '0;
         key_count_ff <= '0;
         sched_ff     <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         kidx_ff      <= kidx_in;
         key_count_ff <= key_count_in;
         sched_ff     <= sched_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff    <= si_in;
      sj_ff    <= sj_in;
      fwd_ff   <= fwd_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      ks_in        = ks_ff;
      last_out_in  = last_out_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.out_ld && out_free) begin
         rsp_valid_in = 1'b1;
         result_in    = value_ff ^ ks;
         ks_in        = ks;
         last_out_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      ks_ff       <= ks_in;
      last_out_ff <= last_out_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_byte    = result_ff;
   assign rsp_chan.keystream_byte = ks_ff;
   assign rsp_chan.last_out       = last_out_ff;

endmodule
